// ===== rtl/core/wmc_pkg.sv =====
// Shared types and constants of the white-balance and colour-matrix unit.
`default_nettype none

package wmc_pkg;

  localparam int unsigned PixW   = 16;
  localparam int unsigned GainW  = 18;
  localparam int unsigned CoefW  = 18;
  localparam int unsigned BalW   = 34;
  localparam int unsigned RowW   = 3 * CoefW;
  localparam int unsigned ProdW  = CoefW + BalW + 1;
  localparam int unsigned SumW   = 54;
  localparam int unsigned CompW  = 20;
  localparam int unsigned TotalW = 26;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [BalW-1:0]          bal_t;
  typedef logic [RowW-1:0]          row_t;
  typedef logic signed [CompW-1:0]  comp_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainRed   = 3'd0,
    CfgGainBlue  = 3'd1,
    CfgConvertEn = 3'd2,
    CfgRowRed    = 3'd3,
    CfgRowGreen  = 3'd4,
    CfgRowBlue   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic sof;
  } stage_ctl_t;

  localparam logic [GainW-1:0] GainUnity  = 18'd16384;
  localparam row_t             IdentRed   = 54'd16384;
  localparam row_t             IdentGreen = 54'd4294967296;
  localparam row_t             IdentBlue  = 54'd1125899906842624;

  localparam logic signed [SumW-1:0] RoundBias = 54'sd134217728;
  localparam comp_t                  OneQ15    = 20'sd32768;
  localparam comp_t                  CompMax   = 20'sd524287;
  localparam comp_t                  CompMin   = -20'sd524288;

endpackage

`default_nettype wire

// ===== rtl/core/wmc_bal.sv =====
// White-balance stage: red and blue gain multipliers, green passed at unity.
`default_nettype none

module wmc_bal (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic [wmc_pkg::PixW-1:0]      in_red_i,
  input  wire logic [wmc_pkg::PixW-1:0]      in_green_i,
  input  wire logic [wmc_pkg::PixW-1:0]      in_blue_i,
  input  wire logic [wmc_pkg::GainW-1:0]     gain_red_i,
  input  wire logic [wmc_pkg::GainW-1:0]     gain_blue_i,
  output wmc_pkg::bal_t [2:0]                bal_o
);

  wmc_pkg::bal_t [2:0] bal_d, bal_q;

  always_comb begin
    bal_d[0] = wmc_pkg::BalW'(in_red_i) * wmc_pkg::BalW'(gain_red_i);
    bal_d[1] = wmc_pkg::BalW'({in_green_i, 14'd0});
    bal_d[2] = wmc_pkg::BalW'(in_blue_i) * wmc_pkg::BalW'(gain_blue_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bal_q <= bal_d;
    end
  end

  assign bal_o = bal_q;

endmodule

`default_nettype wire

// ===== rtl/core/wmc_lane.sv =====
// One output lane: three coefficient products, then sum, rounding and saturation.
`default_nettype none

module wmc_lane (
  input  wire logic                clk_i,
  input  wire logic                adv_i,
  input  wire wmc_pkg::bal_t [2:0] bal_i,
  input  wire wmc_pkg::row_t       row_i,
  output wmc_pkg::comp_t           dev_o
);

  logic signed [wmc_pkg::CoefW-1:0] coef [3];
  logic signed [wmc_pkg::ProdW-1:0] prod_d [3];
  logic signed [wmc_pkg::ProdW-1:0] prod_q [3];
  logic signed [wmc_pkg::SumW-1:0]  sum;
  logic signed [wmc_pkg::SumW-1:0]  shifted;
  logic signed [25:0]               rnd;
  wmc_pkg::comp_t                   dev_d, dev_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      coef[k]   = row_i[k*wmc_pkg::CoefW +: wmc_pkg::CoefW];
      prod_d[k] = coef[k] * $signed({1'b0, bal_i[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    sum = wmc_pkg::SumW'(prod_q[0]) + wmc_pkg::SumW'(prod_q[1])
        + wmc_pkg::SumW'(prod_q[2]) + wmc_pkg::RoundBias;
    shifted = sum >>> 28;
    rnd     = shifted[25:0];
    if (rnd > 26'(wmc_pkg::CompMax)) begin
      dev_d = wmc_pkg::CompMax;
    end else if (rnd < 26'(wmc_pkg::CompMin)) begin
      dev_d = wmc_pkg::CompMin;
    end else begin
      dev_d = rnd[wmc_pkg::CompW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dev_q <= dev_d;
    end
  end

  assign dev_o = dev_q;

endmodule

`default_nettype wire

// ===== rtl/core/wmc_merge.sv =====
// Merge stage: minimum and maximum over the lanes, flags, per-image statistics and output register.
`default_nettype none

module wmc_merge #(
  parameter int unsigned COUNT_BITS = 26
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire wmc_pkg::stage_ctl_t            ctl_i,
  input  wire wmc_pkg::comp_t [2:0]           dev_i,
  output logic                                out_valid_o,
  output wmc_pkg::comp_t                      out_red_o,
  output wmc_pkg::comp_t                      out_green_o,
  output wmc_pkg::comp_t                      out_blue_o,
  output logic                                is_negative_o,
  output logic                                is_over_range_o,
  output logic [wmc_pkg::TotalW-1:0]          negative_total_o,
  output logic [wmc_pkg::TotalW-1:0]          over_range_total_o,
  output wmc_pkg::comp_t                      peak_component_o
);

  wmc_pkg::comp_t        mn, mx;
  logic                  neg_hit, ovr_hit, take;
  logic [COUNT_BITS-1:0] neg_base, ovr_base, neg_d, ovr_d, neg_q, ovr_q;
  wmc_pkg::comp_t        max_base, max_d, max_q;
  wmc_pkg::comp_t [2:0]  dev_q;
  logic                  valid_q, neg_flag_q, ovr_flag_q;

  assign take = adv_i && ctl_i.valid;

  always_comb begin
    mn = dev_i[0];
    mx = dev_i[0];
    for (int k = 1; k < 3; k++) begin
      if (dev_i[k] < mn) begin
        mn = dev_i[k];
      end
      if (dev_i[k] > mx) begin
        mx = dev_i[k];
      end
    end
    neg_hit  = mn[wmc_pkg::CompW-1];
    ovr_hit  = mx > wmc_pkg::OneQ15;
    neg_base = ctl_i.sof ? '0 : neg_q;
    ovr_base = ctl_i.sof ? '0 : ovr_q;
    max_base = ctl_i.sof ? '0 : max_q;
    neg_d    = (neg_hit && neg_base != '1) ? neg_base + COUNT_BITS'(1) : neg_base;
    ovr_d    = (ovr_hit && ovr_base != '1) ? ovr_base + COUNT_BITS'(1) : ovr_base;
    max_d    = (mx > max_base) ? mx : max_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      neg_q   <= '0;
      ovr_q   <= '0;
      max_q   <= '0;
    end else begin
      if (adv_i) begin
        valid_q <= ctl_i.valid;
      end
      if (take) begin
        neg_q <= neg_d;
        ovr_q <= ovr_d;
        max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dev_q      <= dev_i;
      neg_flag_q <= neg_hit;
      ovr_flag_q <= ovr_hit;
    end
  end

  generate
    if (COUNT_BITS > wmc_pkg::TotalW) begin : g_clip
      assign negative_total_o   = (|neg_q[COUNT_BITS-1:wmc_pkg::TotalW]) ? '1
                                  : neg_q[wmc_pkg::TotalW-1:0];
      assign over_range_total_o = (|ovr_q[COUNT_BITS-1:wmc_pkg::TotalW]) ? '1
                                  : ovr_q[wmc_pkg::TotalW-1:0];
    end else begin : g_ext
      assign negative_total_o   = wmc_pkg::TotalW'(neg_q);
      assign over_range_total_o = wmc_pkg::TotalW'(ovr_q);
    end
  endgenerate

  assign out_valid_o      = valid_q;
  assign out_red_o        = dev_q[0];
  assign out_green_o      = dev_q[1];
  assign out_blue_o       = dev_q[2];
  assign is_negative_o    = neg_flag_q;
  assign is_over_range_o  = ovr_flag_q;
  assign peak_component_o = max_q;

`ifndef SYNTHESIS
  a_peak_non_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !max_q[wmc_pkg::CompW-1])
    else $error("Peak component has gone negative.");

  a_over_range_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_over_range_o |-> peak_component_o > wmc_pkg::OneQ15)
    else $error("Over-range beat not reflected in the peak component.");

  a_negative_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_negative_o |-> negative_total_o != '0)
    else $error("Negative beat not reflected in the negative total.");

  a_stats_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(neg_q) && $stable(ovr_q) && $stable(max_q))
    else $error("Statistics changed without a beat in the merge stage.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/white_balance_color_matrix_unit.sv =====
// White balance and 3x3 colour correction: two valid/ready pixel channels with per-image statistics.
//
// The input channel takes one camera RGB pixel per beat (unsigned Q1.15) together with a
// start-of-image marker. The output channel gives the developed pixel (signed Q4.15,
// saturated), negative and over-range flags, and the running image statistics.
// Registers are written through cfg_we_i, cfg_index_i and cfg_data_i;
// they should only be changed while no pixels are in flight.
// The datapath is a four-stage pipeline: gain multipliers, three parallel matrix lanes
// (products, then sum with rounding and saturation), and a merge stage that forms the
// flags and statistics and holds the output register. An accepted pixel moves through the
// balance, product, lane result and merge registers in turn. One pixel is accepted every
// cycle while the receiver takes results; the whole pipeline advances together, so when the
// receiver stalls with a result pending, every stage holds and in_ready_o falls.
// Reset empties the pipeline, loads unity gains, bypass mode and the identity matrix,
// and clears the statistics. The statistics also clear on a pixel marked as start of
// image, before that pixel is counted.
`default_nettype none

module white_balance_color_matrix_unit #(
  parameter int unsigned COUNT_BITS = 26
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [wmc_pkg::PixW-1:0]        in_red_i,
  input  wire logic [wmc_pkg::PixW-1:0]        in_green_i,
  input  wire logic [wmc_pkg::PixW-1:0]        in_blue_i,
  input  wire logic                            start_of_image_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [wmc_pkg::CompW-1:0]     out_red_o,
  output logic signed [wmc_pkg::CompW-1:0]     out_green_o,
  output logic signed [wmc_pkg::CompW-1:0]     out_blue_o,
  output logic                                 is_negative_o,
  output logic                                 is_over_range_o,
  output logic [wmc_pkg::TotalW-1:0]           negative_total_o,
  output logic [wmc_pkg::TotalW-1:0]           over_range_total_o,
  output logic signed [wmc_pkg::CompW-1:0]     peak_component_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [wmc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [wmc_pkg::RowW-1:0]        cfg_data_i
);

  logic [wmc_pkg::GainW-1:0] gain_red_q, gain_blue_q;
  logic                      convert_en_q;
  wmc_pkg::row_t             row_q [3];
  wmc_pkg::row_t             row_eff [3];
  wmc_pkg::row_t             ident [3];
  wmc_pkg::stage_ctl_t       ctl1_q, ctl2_q, ctl3_q;
  wmc_pkg::bal_t [2:0]       bal;
  wmc_pkg::comp_t [2:0]      dev;
  wmc_pkg::comp_t            out_red, out_green, out_blue, peak;
  logic                      adv;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_red_q   <= wmc_pkg::GainUnity;
      gain_blue_q  <= wmc_pkg::GainUnity;
      convert_en_q <= 1'b0;
      row_q[0]     <= wmc_pkg::IdentRed;
      row_q[1]     <= wmc_pkg::IdentGreen;
      row_q[2]     <= wmc_pkg::IdentBlue;
    end else if (cfg_we_i) begin
      unique case (wmc_pkg::cfg_idx_e'(cfg_index_i))
        wmc_pkg::CfgGainRed:   gain_red_q   <= cfg_data_i[wmc_pkg::GainW-1:0];
        wmc_pkg::CfgGainBlue:  gain_blue_q  <= cfg_data_i[wmc_pkg::GainW-1:0];
        wmc_pkg::CfgConvertEn: convert_en_q <= cfg_data_i[0];
        wmc_pkg::CfgRowRed:    row_q[0]     <= cfg_data_i;
        wmc_pkg::CfgRowGreen:  row_q[1]     <= cfg_data_i;
        wmc_pkg::CfgRowBlue:   row_q[2]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // In bypass each lane multiplies its own balanced component by unity.
  always_comb begin
    ident[0] = wmc_pkg::IdentRed;
    ident[1] = wmc_pkg::IdentGreen;
    ident[2] = wmc_pkg::IdentBlue;
    for (int k = 0; k < 3; k++) begin
      row_eff[k] = convert_en_q ? row_q[k] : ident[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (adv) begin
      ctl1_q <= '{valid: in_valid_i, sof: start_of_image_i};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  wmc_bal u_bal (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .gain_red_i  (gain_red_q),
    .gain_blue_i (gain_blue_q),
    .bal_o       (bal)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    wmc_lane u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .bal_i (bal),
      .row_i (row_eff[g]),
      .dev_o (dev[g])
    );
  end

  wmc_merge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .adv_i              (adv),
    .ctl_i              (ctl3_q),
    .dev_i              (dev),
    .out_valid_o        (out_valid_o),
    .out_red_o          (out_red),
    .out_green_o        (out_green),
    .out_blue_o         (out_blue),
    .is_negative_o      (is_negative_o),
    .is_over_range_o    (is_over_range_o),
    .negative_total_o   (negative_total_o),
    .over_range_total_o (over_range_total_o),
    .peak_component_o   (peak)
  );

  assign out_red_o        = out_red;
  assign out_green_o      = out_green;
  assign out_blue_o       = out_blue;
  assign peak_component_o = peak;

endmodule

`default_nettype wire
